>>> hdl/assert_macros.svh
// Assertion macros used by the checker of the voice mixer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SVM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SVM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/svm_pkg.sv
// Package of the voice mixer: operation codes, field widths and control structs.
package svm_pkg;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_PLAY = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam int OP_W     = 2;
  localparam int CID_W    = 4;
  localparam int SIDX_W   = 12;
  localparam int SMP_W    = 16;
  localparam int GAIN_W   = 16;
  localparam int MIX_W    = 22;
  localparam int COUNT_W  = 5;
  localparam int PROD_W   = SMP_W + GAIN_W + 1;
  localparam int GAIN_SHIFT = 14;

  typedef struct packed {
    logic accept;
    logic load;
    logic play_start;
    logic scan;
    logic commit;
    logic tick_start;
    logic tick_issue;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } dp_sts_t;

endpackage

>>> hdl/svm_if.sv
// Handshake interfaces for the input items and the mixed results.
interface svm_item_if import svm_pkg::*;;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [CID_W-1:0]    clip_id;
  logic [SIDX_W-1:0]   sample_index;
  logic signed [SMP_W-1:0] sample_value;
  logic                last_sample;
  logic [GAIN_W-1:0]   gain;

  modport source (output valid, op, clip_id, sample_index, sample_value, last_sample, gain,
                  input ready);
  modport sink (input valid, op, clip_id, sample_index, sample_value, last_sample, gain,
                output ready);
endinterface

interface svm_result_if import svm_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [MIX_W-1:0] mixed_sample;
  logic [COUNT_W-1:0]      active_voices;

  modport source (output valid, mixed_sample, active_voices, input ready);
  modport sink (input valid, mixed_sample, active_voices, output ready);
endinterface

>>> hdl/svm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module svm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/svm_ctrl.sv
// Controller state machine of the voice mixer: sequences load, play scan and tick passes.
module svm_ctrl import svm_pkg::*; #(
  parameter int VOICES = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  input  logic [OP_W-1:0] item_op_i,
  output logic            item_ready_o,
  input  logic            res_ready_i,
  output logic            res_valid_o,
  input  dp_sts_t         sts_i,
  output ctl_cmd_t        cmd_o,
  output logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] voice_idx_o
);

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam logic [VW-1:0] LAST_VOICE = VW'(VOICES - 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_COMMIT = 6'b000100,
    S_RUN    = 6'b001000,
    S_DRAIN  = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e        state_q, state_d;
  logic [VW-1:0] vidx_q, vidx_d;
  logic          out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    vidx_d  = vidx_q;
    cmd_o   = '0;
    item_ready_o = (state_q == S_IDLE);
    cmd_o.accept = item_valid_i && (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.accept) begin
          vidx_d = '0;
          if (item_op_i == OP_LOAD) begin
            cmd_o.load = 1'b1;
          end else if (item_op_i == OP_PLAY) begin
            cmd_o.play_start = 1'b1;
            state_d = S_SCAN;
          end else if (item_op_i == OP_TICK) begin
            cmd_o.tick_start = 1'b1;
            state_d = S_RUN;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (vidx_q == LAST_VOICE) begin
          state_d = S_COMMIT;
        end else begin
          vidx_d = vidx_q + 1'b1;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d = S_IDLE;
      end
      S_RUN: begin
        cmd_o.tick_issue = 1'b1;
        if (vidx_q == LAST_VOICE) begin
          state_d = S_DRAIN;
        end else begin
          vidx_d = vidx_q + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || res_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vidx_q      <= vidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign voice_idx_o = vidx_q;
  assign res_valid_o = out_valid_q;

endmodule

>>> hdl/svm_dp.sv
// Datapath of the voice mixer: clip store, clip lengths, voice table and mix pipeline.
module svm_dp import svm_pkg::*; #(
  parameter int VOICES     = 16,
  parameter int CLIPS      = 16,
  parameter int CLIP_DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctl_cmd_t                 cmd_i,
  input  logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] voice_idx_i,
  input  logic [CID_W-1:0]         clip_id_i,
  input  logic [SIDX_W-1:0]        sample_index_i,
  input  logic signed [SMP_W-1:0]  sample_value_i,
  input  logic                     last_sample_i,
  input  logic [GAIN_W-1:0]        gain_i,
  output dp_sts_t                  sts_o,
  output logic signed [MIX_W-1:0]  mixed_sample_o,
  output logic [COUNT_W-1:0]       active_voices_o
);

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW = (CLIPS > 1) ? $clog2(CLIPS) : 1;
  localparam int IW = (CLIP_DEPTH > 1) ? $clog2(CLIP_DEPTH) : 1;
  localparam int LW = $clog2(CLIP_DEPTH + 1);
  localparam int AW = CW + IW;

  // Voice table.
  logic              live_q [VOICES];
  logic [CID_W-1:0]  vclip_q [VOICES];
  logic [LW-1:0]     vpos_q [VOICES];
  logic [GAIN_W-1:0] vgain_q [VOICES];
  logic [LW-1:0]     clen_q [CLIPS];

  // Latched play item and scan results.
  logic [CID_W-1:0]  cid_q;
  logic [GAIN_W-1:0] gain_q;
  logic              free_found_q;
  logic [VW-1:0]     free_idx_q;
  logic [VW-1:0]     max_idx_q;
  logic [LW-1:0]     max_pos_q;

  // Mix pipeline.
  logic                     s1_q, s2_q;
  logic [GAIN_W-1:0]        s1_gain_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [MIX_W-1:0]  acc_q, mix_q;
  logic [COUNT_W-1:0]       count_q, act_q;

  logic              cur_live;
  logic [CID_W-1:0]  cur_clip;
  logic [LW-1:0]     cur_pos, cur_len, new_pos;
  logic [GAIN_W-1:0] cur_gain;
  logic              hit, stay_live, play_ok, load_ok;
  logic [CW-1:0]     len_addr;
  logic [VW-1:0]     pick;
  logic [AW-1:0]     waddr, raddr;
  logic [SMP_W-1:0]  rdata;
  logic signed [PROD_W-1:0] prod_shift;

  assign cur_live = live_q[voice_idx_i];
  assign cur_clip = vclip_q[voice_idx_i];
  assign cur_pos  = vpos_q[voice_idx_i];
  assign cur_gain = vgain_q[voice_idx_i];
  assign len_addr = cmd_i.tick_issue ? CW'(cur_clip) : CW'(cid_q);
  assign cur_len  = clen_q[len_addr];

  assign hit       = cur_live && (cur_pos < cur_len);
  assign new_pos   = cur_pos + LW'(hit);
  assign stay_live = cur_live && (new_pos < cur_len);

  assign play_ok = (32'(cid_q) < 32'(CLIPS)) && (cur_len != '0);
  assign load_ok = (32'(clip_id_i) < 32'(CLIPS)) && (32'(sample_index_i) < 32'(CLIP_DEPTH));
  assign pick    = free_found_q ? free_idx_q : max_idx_q;

  assign waddr = {CW'(clip_id_i), IW'(sample_index_i)};
  assign raddr = {CW'(cur_clip), IW'(cur_pos)};

  svm_ram #(
    .WIDTH (SMP_W),
    .DEPTH (2 ** AW)
  ) u_clip_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && load_ok),
    .waddr_i (waddr),
    .wdata_i (sample_value_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < VOICES; v++) begin
        live_q[v]  <= 1'b0;
        vclip_q[v] <= '0;
        vpos_q[v]  <= '0;
        vgain_q[v] <= '0;
      end
      for (int c = 0; c < CLIPS; c++) begin
        clen_q[c] <= '0;
      end
      s1_q <= 1'b0;
      s2_q <= 1'b0;
    end else begin
      if (cmd_i.load && load_ok && last_sample_i) begin
        clen_q[CW'(clip_id_i)] <= LW'(32'(sample_index_i) + 32'd1);
      end
      if (cmd_i.commit && play_ok) begin
        live_q[pick]  <= 1'b1;
        vclip_q[pick] <= cid_q;
        vpos_q[pick]  <= '0;
        vgain_q[pick] <= gain_q;
      end
      if (cmd_i.tick_issue) begin
        live_q[voice_idx_i] <= stay_live;
        vpos_q[voice_idx_i] <= new_pos;
      end
      s1_q <= cmd_i.tick_issue && hit;
      s2_q <= s1_q;
    end
  end

  // Play item latch and steal search.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cid_q  <= clip_id_i;
      gain_q <= gain_i;
    end
    if (cmd_i.play_start) begin
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      max_idx_q    <= '0;
      max_pos_q    <= '0;
    end else if (cmd_i.scan) begin
      if (!free_found_q && !cur_live) begin
        free_found_q <= 1'b1;
        free_idx_q   <= voice_idx_i;
      end
      if (voice_idx_i == '0 || cur_pos > max_pos_q) begin
        max_idx_q <= voice_idx_i;
        max_pos_q <= cur_pos;
      end
    end
  end

  // Product and accumulation; negative products floor through the arithmetic shift.
  assign prod_shift = prod_q >>> GAIN_SHIFT;

  always_ff @(posedge clk_i) begin
    s1_gain_q <= cur_gain;
    prod_q    <= $signed(rdata) * $signed({1'b0, s1_gain_q});
    if (cmd_i.tick_start) begin
      acc_q   <= '0;
      count_q <= '0;
    end else begin
      if (s2_q) begin
        acc_q <= acc_q + MIX_W'(prod_shift);
      end
      if (cmd_i.tick_issue) begin
        count_q <= count_q + COUNT_W'(stay_live);
      end
    end
    if (cmd_i.out_load) begin
      mix_q <= acc_q;
      act_q <= count_q;
    end
  end

  assign sts_o.pipe_busy = s1_q || s2_q;
  assign mixed_sample_o  = mix_q;
  assign active_voices_o = act_q;

endmodule

>>> hdl/sample_voice_mixer.sv
// Top level of the sixteen-voice sample playback mixer.
//
//  Channel   Dir  Handshake      Payload
//  item_i    in   valid/ready    op, clip_id, sample_index, sample_value, last_sample, gain
//  result_o  out  valid/ready    mixed_sample, active_voices
//
// A load is taken without leaving the idle state. A play scans the voices one per cycle
// to find the lowest free voice or the one furthest into its clip, then claims it.
// A tick reads the voices one per cycle through the single read port of the clip RAM,
// waits while the multiply and accumulate stages drain, then loads the output register.
// Reset is asynchronous and active low; it empties every clip and frees every voice. The
// clip RAM itself is not cleared and needs no clearing pass.
// A finished result waits in the output register; a further tick stalls only at its end.
module sample_voice_mixer import svm_pkg::*; #(
  parameter int VOICES     = 16,
  parameter int CLIPS      = 16,
  parameter int CLIP_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  svm_item_if.sink    item_i,
  svm_result_if.source result_o
);

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

  ctl_cmd_t      cmd;
  dp_sts_t       sts;
  logic [VW-1:0] voice_idx;

  // The controller owns the handshakes and walks the voice index; the datapath holds
  // all item, voice and clip state.
  svm_ctrl #(
    .VOICES (VOICES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_i.valid),
    .item_op_i    (item_i.op),
    .item_ready_o (item_i.ready),
    .res_ready_i  (result_o.ready),
    .res_valid_o  (result_o.valid),
    .sts_i        (sts),
    .cmd_o        (cmd),
    .voice_idx_o  (voice_idx)
  );

  svm_dp #(
    .VOICES     (VOICES),
    .CLIPS      (CLIPS),
    .CLIP_DEPTH (CLIP_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .voice_idx_i     (voice_idx),
    .clip_id_i       (item_i.clip_id),
    .sample_index_i  (item_i.sample_index),
    .sample_value_i  (item_i.sample_value),
    .last_sample_i   (item_i.last_sample),
    .gain_i          (item_i.gain),
    .sts_o           (sts),
    .mixed_sample_o  (result_o.mixed_sample),
    .active_voices_o (result_o.active_voices)
  );

endmodule

>>> hdl/svm_checker.sv
// Port-level checker for the voice mixer, bound to the top level.
`include "assert_macros.svh"

module svm_checker import svm_pkg::*; #(
  parameter int VOICES = 16
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    item_valid_i,
  input logic                    item_ready_i,
  input logic [OP_W-1:0]         item_op_i,
  input logic                    res_valid_i,
  input logic                    res_ready_i,
  input logic signed [MIX_W-1:0] res_mixed_i,
  input logic [COUNT_W-1:0]      res_active_i
);

  logic item_xfer;
  assign item_xfer = item_valid_i && item_ready_i;

  `SVM_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i && $stable(res_mixed_i) && $stable(res_active_i), "stalled result changed")
  `SVM_ASSERT_NOW(a_count_range, clk_i, rst_ni, res_valid_i && (VOICES < 32), 32'(res_active_i) <= 32'(VOICES), "active voice count above voice total")
  `SVM_ASSERT_NEXT(a_busy_after_work, clk_i, rst_ni, item_xfer && (item_op_i == OP_PLAY || item_op_i == OP_TICK), !item_ready_i, "ready high straight after play or tick")
  `SVM_ASSERT_NEXT(a_load_single, clk_i, rst_ni, item_xfer && item_op_i == OP_LOAD, item_ready_i, "load transfer did not complete in one cycle")

endmodule

bind sample_voice_mixer svm_checker #(
  .VOICES (VOICES)
) u_svm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .item_valid_i (item_i.valid),
  .item_ready_i (item_i.ready),
  .item_op_i    (item_i.op),
  .res_valid_i  (result_o.valid),
  .res_ready_i  (result_o.ready),
  .res_mixed_i  (result_o.mixed_sample),
  .res_active_i (result_o.active_voices)
);

>>> tb/sample_voice_mixer_tb.sv
// Regression bench for the sample voice mixer: predicts every mixed frame and checks it.
`timescale 1ns / 1ps

module sample_voice_mixer_tb;
  import svm_pkg::*;

  localparam int NVOICE   = 16;
  localparam int NCLIP    = 16;
  localparam int DEPTH    = 4096;
  localparam int SETTLE   = 64;

  typedef struct packed {
    logic signed [MIX_W-1:0] mix;
    logic [COUNT_W-1:0]      count;
  } frame_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  svm_item_if   item_if ();
  svm_result_if res_if ();

  sample_voice_mixer uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if.sink),
    .result_o(res_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: a copy of the clip store and the voice table.
  logic signed [SMP_W-1:0] clip_mem [NCLIP*DEPTH];
  logic [12:0]             clip_len [NCLIP];
  logic                    v_live   [NVOICE];
  logic [CID_W-1:0]        v_clip   [NVOICE];
  logic [12:0]             v_pos    [NVOICE];
  logic [GAIN_W-1:0]       v_gain   [NVOICE];

  frame_t expected_frames[$];
  int     mismatches = 0;
  bit     stall_en = 1'b1;
  // Number of entries written from index zero upwards in each clip; plays only run over written entries.
  int     filled [NCLIP];

  // Applies one accepted item to the predictor and queues the frame that a tick yields.
  task automatic predict_item(input logic [1:0] op, input logic [3:0] cid,
                              input logic [11:0] idx, input logic signed [15:0] sval,
                              input logic last, input logic [15:0] gain);
    int pick;
    longint acc;
    longint prod;
    int cnt;
    frame_t f;
    pick = -1;
    acc = 0;
    cnt = 0;
    case (op)
      OP_LOAD: begin
        clip_mem[cid*DEPTH+idx] = sval;
        if (last) clip_len[cid] = 13'(idx) + 13'd1;
      end
      OP_PLAY: begin
        if (clip_len[cid] != 0) begin
          for (int v = 0; v < NVOICE; v++)
            if (!v_live[v] && pick < 0) pick = v;
          if (pick < 0) begin
            pick = 0;
            for (int v = 1; v < NVOICE; v++)
              if (v_pos[v] > v_pos[pick]) pick = v;
          end
          v_live[pick] = 1'b1;
          v_clip[pick] = cid;
          v_pos[pick]  = '0;
          v_gain[pick] = gain;
        end
      end
      OP_TICK: begin
        for (int v = 0; v < NVOICE; v++) begin
          if (v_live[v]) begin
            if (v_pos[v] < clip_len[v_clip[v]]) begin
              prod = longint'(clip_mem[v_clip[v]*DEPTH+v_pos[v]]) * longint'({1'b0, v_gain[v]});
              // Arithmetic shift floors towards minus infinity, as the mixer does.
              acc += prod >>> GAIN_SHIFT;
              v_pos[v]++;
            end
            if (v_pos[v] >= clip_len[v_clip[v]]) v_live[v] = 1'b0;
            else cnt++;
          end
        end
        f.mix = acc[MIX_W-1:0];
        f.count = cnt[COUNT_W-1:0];
        expected_frames.push_back(f);
      end
      default: ;
    endcase
  endtask

  // Drives one item and holds it until the transfer happens.
  task automatic send_item(input logic [1:0] op, input logic [3:0] cid,
                           input logic [11:0] idx, input logic signed [15:0] sval,
                           input logic last, input logic [15:0] gain);
    item_if.valid        <= 1'b1;
    item_if.op           <= op;
    item_if.clip_id      <= cid;
    item_if.sample_index <= idx;
    item_if.sample_value <= sval;
    item_if.last_sample  <= last;
    item_if.gain         <= gain;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    predict_item(op, cid, idx, sval, last, gain);
  endtask

  // Lowers valid for a random gap now and then, so the sender works in bursts.
  int burst_left = 0;
  task automatic maybe_gap();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        item_if.valid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic idle_sender();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    idle_sender();
    while (expected_frames.size() != 0) @(posedge clk_i);
  endtask

  // Loads a whole clip of the given length with random or fixed content.
  task automatic load_clip(input int cid, input int len, input bit extremes);
    logic signed [15:0] s;
    for (int i = 0; i < len; i++) begin
      if (extremes) s = (i % 2) ? 16'sh7fff : 16'sh8000;
      else s = 16'($urandom);
      maybe_gap();
      send_item(OP_LOAD, 4'(cid), 12'(i), s, i == len - 1, 16'($urandom));
    end
    if (len > filled[cid]) filled[cid] = len;
  endtask

  // Directed: extreme samples and gains, empty clip, unknown op, reload.
  task automatic test_directed();
    send_item(OP_PLAY, 4'd5, 12'd0, 16'sd0, 1'b0, 16'hffff); // empty clip, ignored
    send_item(OP_TICK, 4'd0, 12'd0, 16'sd0, 1'b0, 16'd0);
    load_clip(0, 4, 1'b1);
    load_clip(15, 2, 1'b0);
    send_item(OP_PLAY, 4'd0, 12'hfff, 16'sd0, 1'b1, 16'hffff);
    send_item(OP_PLAY, 4'd15, 12'd0, 16'sd0, 1'b0, 16'h4000);
    send_item(2'd3, 4'hf, 12'hfff, 16'shffff, 1'b1, 16'hffff); // unknown op
    send_item(OP_TICK, 4'hf, 12'hfff, 16'shffff, 1'b1, 16'hffff);
    // Load without last mark: store changes, length stays.
    send_item(OP_LOAD, 4'd0, 12'd1, 16'sh1234, 1'b0, 16'd0);
    send_item(OP_TICK, 4'd0, 12'd0, 16'sd0, 1'b0, 16'd0);
    // Shrink clip 0 under its live voice: it is freed on the next tick.
    send_item(OP_LOAD, 4'd0, 12'd0, 16'sh8000, 1'b1, 16'd0);
    send_item(OP_TICK, 4'd0, 12'd0, 16'sd0, 1'b0, 16'd0);
    send_item(OP_TICK, 4'd0, 12'd0, 16'sd0, 1'b0, 16'd0);
    // Top sample index, then restore clip 0 to four entries.
    send_item(OP_LOAD, 4'd1, 12'hfff, 16'sh7fff, 1'b0, 16'd0);
    load_clip(0, 4, 1'b1);
    wait_drained();
  endtask

  // All voices busy: further plays steal the voice furthest into its clip.
  task automatic test_voice_stealing();
    load_clip(2, 8, 1'b0);
    for (int v = 0; v < NVOICE; v++) begin
      send_item(OP_PLAY, 4'd2, 12'd0, 16'sd0, 1'b0, 16'($urandom));
      if (v % 4 == 3) send_item(OP_TICK, 4'd0, 12'd0, 16'sd0, 1'b0, 16'd0);
    end
    send_item(OP_PLAY, 4'd0, 12'd0, 16'sd0, 1'b0, 16'hffff);
    send_item(OP_PLAY, 4'd0, 12'd0, 16'sd0, 1'b0, 16'h0000);
    repeat (10) send_item(OP_TICK, 4'd0, 12'd0, 16'sd0, 1'b0, 16'd0);
    wait_drained();
  endtask

  // Random traffic: mostly plays and ticks over written clips, with reloads and noise.
  task automatic test_random_traffic(input int n_items);
    int r;
    int cid;
    int len;
    for (int k = 0; k < n_items; k++) begin
      maybe_gap();
      r = $urandom_range(0, 99);
      cid = $urandom_range(0, NCLIP - 1);
      if (k == n_items / 2) begin
        wait_drained(); // sender holds off until every frame is back
      end
      if (r < 8) begin
        len = (r == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        load_clip(cid, len, 1'b0);
      end else if (r < 12 && filled[cid] > 0) begin
        // Relength within the written range so no unwritten entry is ever read.
        send_item(OP_LOAD, 4'(cid), 12'($urandom_range(0, filled[cid] - 1)), 16'($urandom),
                  1'b1, 16'($urandom));
      end else if (r < 14) begin
        send_item(2'd3, 4'(cid), 12'($urandom), 16'($urandom), 1'($urandom), 16'($urandom));
      end else if (r < 40) begin
        // Plays on empty clips are legal and ignored.
        send_item(OP_PLAY, 4'(cid), 12'($urandom), 16'($urandom), 1'($urandom),
                  ($urandom_range(0, 5) == 0) ? 16'hffff : 16'($urandom));
      end else begin
        send_item(OP_TICK, 4'(cid), 12'($urandom), 16'($urandom), 1'($urandom),
                  16'($urandom));
      end
    end
    wait_drained();
  endtask

  // Receiver stalls in runs, with stall-free stretches too.
  int stall_phase = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= (stall_phase + 1) % 97;
      if (!stall_en || stall_phase > 60) res_if.ready <= 1'b1;
      else res_if.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Checks every frame transfer against the oldest prediction.
  always @(posedge clk_i) begin
    frame_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected frame: mix %0d count %0d", res_if.mixed_sample,
                   res_if.active_voices);
      end else begin
        want = expected_frames.pop_front();
        if (res_if.mixed_sample !== want.mix || res_if.active_voices !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("frame mismatch: mix exp %0d got %0d, count exp %0d got %0d",
                     want.mix, res_if.mixed_sample, want.count, res_if.active_voices);
        end
      end
    end
  end

  initial begin
    item_if.valid        <= 1'b0;
    item_if.op           <= OP_LOAD;
    item_if.clip_id      <= '0;
    item_if.sample_index <= '0;
    item_if.sample_value <= '0;
    item_if.last_sample  <= 1'b0;
    item_if.gain         <= '0;
    for (int c = 0; c < NCLIP; c++) begin
      clip_len[c] = '0;
      filled[c] = 0;
    end
    for (int v = 0; v < NVOICE; v++) begin
      v_live[v] = 1'b0;
      v_clip[v] = '0;
      v_pos[v] = '0;
      v_gain[v] = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_voice_stealing();
    test_random_traffic(420);
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("sample_voice_mixer regression: pass");
    end else begin
      $display("sample_voice_mixer regression: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("sample_voice_mixer regression: fail");
    $finish;
  end

endmodule
